FILE: rtl/core/lsa_pkg.sv
package lsa_pkg;

    // Default sizing, handed to the top level parameters
    localparam int CAPACITY_DEF      = 256;
    localparam int ADDRESS_WIDTH_DEF = 64;

    // Fixed field widths of the channel payloads
    localparam int SLOT_FIELD_W = 8;
    localparam int ADDR_FIELD_W = 64;

    // Operation codes
    localparam logic OP_GET  = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic [SLOT_FIELD_W-1:0] slot_in;
        logic                    slot_in_null;
        logic [ADDR_FIELD_W-1:0] address;
    } lsa_in_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot_out;
        logic                    granted;
        logic                    exhausted;
        logic                    definalize;
    } lsa_out_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } lsa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } lsa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } lsa_status_t;

endpackage

FILE: rtl/core/lsa_ctrl.sv
module lsa_ctrl
    import lsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  lsa_status_t status,
    output lsa_cmd_t    cmd
);

    lsa_state_t state_reg;
    lsa_state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance after a transfer in, return once the result is committed
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive handshake and datapath commands
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/lsa_datapath.sv
module lsa_datapath
    import lsa_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lsa_in_t     in_data,
    input  lsa_cmd_t    cmd,
    output lsa_status_t status,
    output logic        out_valid,
    input  logic        out_ready,
    output lsa_out_t    out_data
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int EXT_W  = (CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W;

    // Link entry: top bit marks the stack bottom, the rest is the slot below
    typedef logic [SLOT_W:0] link_t;

    lsa_in_t                  item_reg;
    logic [CNT_W-1:0]         fresh_next_reg;
    logic [CNT_W-1:0]         fresh_next_next;
    logic [SLOT_W-1:0]        reuse_top_reg;
    logic [SLOT_W-1:0]        reuse_top_next;
    logic                     reuse_empty_reg;
    logic                     reuse_empty_next;
    logic [ADDRESS_WIDTH-1:0] last_addr_reg;
    logic [ADDRESS_WIDTH-1:0] last_addr_next;
    link_t                    link_mem_reg [CAPACITY];
    link_t                    rd_data_reg;
    lsa_out_t                 out_data_reg;
    lsa_out_t                 result;
    logic                     out_valid_reg;

    logic [ADDRESS_WIDTH-1:0] item_addr;
    logic [EXT_W-1:0]         slot_ext;
    logic [SLOT_W-1:0]        push_idx;
    logic                     push_en;
    link_t                    push_link;
    logic                     addr_match;
    logic [SLOT_W-1:0]        got;

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
    end

    // Link memory: read the top entry at capture, write on a push commit
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= link_mem_reg[reuse_top_reg];
        end
        if (cmd.commit && push_en)
        begin
            link_mem_reg[push_idx] <= push_link;
        end
    end

    // Decode the item against the allocator state
    always_comb
    begin
        item_addr  = item_reg.address[ADDRESS_WIDTH-1:0];
        slot_ext   = EXT_W'(item_reg.slot_in);
        push_idx   = slot_ext[SLOT_W-1:0];
        push_link  = reuse_empty_reg ? {1'b1, {SLOT_W{1'b0}}} : {1'b0, reuse_top_reg};
        addr_match = (item_addr == last_addr_reg);
        push_en    = 1'b0;
        got        = '0;

        fresh_next_next  = fresh_next_reg;
        reuse_top_next   = reuse_top_reg;
        reuse_empty_next = reuse_empty_reg;
        last_addr_next   = last_addr_reg;
        result           = '0;

        case (item_reg.opcode)
            OP_FREE:
            begin
                last_addr_next = item_addr;
                if (!item_reg.slot_in_null && (slot_ext < EXT_W'(CAPACITY)))
                begin
                    push_en          = 1'b1;
                    reuse_top_next   = push_idx;
                    reuse_empty_next = 1'b0;
                end
            end
            default:
            begin
                if (!reuse_empty_reg)
                begin
                    // Pop: the slot below comes from the read done at capture
                    got            = reuse_top_reg;
                    result.granted = 1'b1;
                    if (rd_data_reg[SLOT_W])
                    begin
                        reuse_empty_next = 1'b1;
                        reuse_top_next   = '0;
                    end
                    else
                    begin
                        reuse_top_next = rd_data_reg[SLOT_W-1:0];
                    end
                end
                else if (fresh_next_reg < CNT_W'(CAPACITY))
                begin
                    got             = fresh_next_reg[SLOT_W-1:0];
                    result.granted  = 1'b1;
                    fresh_next_next = fresh_next_reg + CNT_W'(1);
                end
                else
                begin
                    result.exhausted = 1'b1;
                end

                if (result.granted)
                begin
                    result.slot_out   = SLOT_FIELD_W'(got);
                    result.definalize = addr_match;
                    if (!addr_match)
                    begin
                        last_addr_next = '0;
                    end
                end
            end
        endcase
    end

    // Update allocator state on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_next_reg  <= '0;
            reuse_top_reg   <= '0;
            reuse_empty_reg <= 1'b1;
            last_addr_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            fresh_next_reg  <= fresh_next_next;
            reuse_top_reg   <= reuse_top_next;
            reuse_empty_reg <= reuse_empty_next;
            last_addr_reg   <= last_addr_next;
        end
    end

    // Output register: load on commit, drop after the transfer out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= result;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

FILE: rtl/core/location_slot_allocator.sv
// Slot allocator with a LIFO reuse stack in front of a fresh-slot counter.
// Input channel (in_valid/in_ready/in_data): a get (opcode OP_GET) or a free
// (OP_FREE) carrying slot_in, slot_in_null and the address. Output channel
// (out_valid/out_ready/out_data): exactly one result per item; a free returns
// all zero, a get returns the granted slot or the exhausted flag.
// An item transferred in is held in the item register; its result is
// committed to the output register once that register is free. A new item
// is taken only after the previous one is committed. The link memory read
// that yields the slot below the reuse stack top is registered at capture.
// The block works on one item at a time. The next item is taken while the
// previous result still waits in the output register; when the receiver
// stalls, the item in work holds until the output register frees up, and
// input stays blocked behind it.
// Reset empties the reuse stack, restarts the fresh counter at slot 0 and
// clears the freed-address record. The link memory needs no clearing: only
// entries written by a push are ever used.
module location_slot_allocator
    import lsa_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lsa_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lsa_out_t out_data
);

    lsa_cmd_t    cmd;
    lsa_status_t status;

    lsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lsa_datapath #(
        .CAPACITY      (CAPACITY),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: dv/location_slot_allocator_tb.sv
module location_slot_allocator_tb;
    import lsa_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [8:0]  CAP         = 9'(CAPACITY_DEF);
    localparam logic [63:0] ADDR_MASK   = {64{1'b1}} >> (64 - ADDRESS_WIDTH_DEF);

    // Mirror of the allocator: reuse stack, fresh counter, freed-address record
    class alloc_ledger;
        logic [8:0]  fresh_next  = '0;
        logic [7:0]  stack_top   = '0;
        logic        stack_empty = 1'b1;
        logic [8:0]  below_of [CAP];
        logic [63:0] freed_addr  = '0;
        lsa_out_t    pending_results [$];
        logic [7:0]  held_slots [$];
        int          errors      = 0;
        int          n_requests  = 0;
        int          n_frees     = 0;
        int          n_grants    = 0;
        int          n_exhausted = 0;
        int          n_definalize = 0;

        // Predict the result of one transferred request
        function void take_request(lsa_in_t req);
            lsa_out_t   res;
            logic [8:0] below;
            logic [63:0] addr;
            res  = '0;
            addr = req.address & ADDR_MASK;
            n_requests++;
            if (req.opcode == OP_FREE) begin
                n_frees++;
                freed_addr = addr;
                if (!req.slot_in_null && {1'b0, req.slot_in} < CAP) begin
                    below_of[req.slot_in] = stack_empty ? CAP : {1'b0, stack_top};
                    stack_top   = req.slot_in;
                    stack_empty = 1'b0;
                end
            end else begin
                if (!stack_empty) begin
                    res.slot_out = stack_top;
                    res.granted  = 1'b1;
                    below = below_of[stack_top];
                    if (below >= CAP) begin
                        stack_empty = 1'b1;
                        stack_top   = '0;
                    end else begin
                        stack_top = below[7:0];
                    end
                end else if (fresh_next < CAP) begin
                    res.slot_out = fresh_next[7:0];
                    res.granted  = 1'b1;
                    fresh_next   = fresh_next + 9'd1;
                end else begin
                    res.exhausted = 1'b1;
                    n_exhausted++;
                end
                if (res.granted) begin
                    n_grants++;
                    held_slots.push_back(res.slot_out);
                    if (addr == freed_addr) begin
                        res.definalize = 1'b1;
                        n_definalize++;
                    end else begin
                        freed_addr = '0;
                    end
                end
            end
            pending_results.push_back(res);
        endfunction

        // Compare one transferred result with the oldest prediction
        function void check_response(lsa_out_t got);
            lsa_out_t exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result slot_out=%0d granted=%0b exhausted=%0b definalize=%0b",
                         $time, got.slot_out, got.granted, got.exhausted, got.definalize);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (got.slot_out !== exp_res.slot_out) begin
                $display("%0t: slot_out expected %0d actual %0d",
                         $time, exp_res.slot_out, got.slot_out);
                errors++;
            end
            if (got.granted !== exp_res.granted) begin
                $display("%0t: granted expected %0b actual %0b",
                         $time, exp_res.granted, got.granted);
                errors++;
            end
            if (got.exhausted !== exp_res.exhausted) begin
                $display("%0t: exhausted expected %0b actual %0b",
                         $time, exp_res.exhausted, got.exhausted);
                errors++;
            end
            if (got.definalize !== exp_res.definalize) begin
                $display("%0t: definalize expected %0b actual %0b",
                         $time, exp_res.definalize, got.definalize);
                errors++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    lsa_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    lsa_out_t out_data;

    alloc_ledger ledger;
    bit          quiet    = 1'b0;
    bit          held_off = 1'b0;
    int          cycles   = 0;

    location_slot_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ledger.check_response(out_data);
    end

    // Stall the receiver in bursts, with one long hold-off to back up the input
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!quiet && !held_off && ledger.n_requests >= 500)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            else if (quiet || $urandom_range(3) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic lsa_in_t make_req(logic op, logic [7:0] slot, logic is_null,
                                         logic [63:0] addr);
        lsa_in_t req;
        req.opcode       = op;
        req.slot_in      = slot;
        req.slot_in_null = is_null;
        req.address      = addr;
        return req;
    endfunction

    // Hold valid until the transfer, then, at a gap_pct percent chance unless quiet, idle for a random burst
    task automatic send_req(input lsa_in_t req, input int gap_pct);
        int gap;
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ledger.take_request(req);
        gap = (quiet || $urandom_range(99) >= gap_pct) ? 0 : $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Build a mostly well-formed request: free held slots, get with recent addresses
    task automatic send_random(input int get_pct, input int gap_pct);
        lsa_in_t     req;
        logic [63:0] addr;
        int          pick;
        int          idx;
        req  = make_req(OP_GET, 8'($urandom), 1'b0, {$urandom, $urandom});
        pick = $urandom_range(99);
        if ($urandom_range(99) < get_pct)
        begin
            if (pick < 35)
                req.address = ledger.freed_addr;
            else if (pick < 45)
                req.address = '0;
        end
        else
        begin
            req.opcode       = OP_FREE;
            req.slot_in_null = ($urandom_range(9) == 0);
            if (pick < 70 && ledger.held_slots.size() > 0)
            begin
                idx = $urandom_range(ledger.held_slots.size() - 1);
                req.slot_in = ledger.held_slots[idx];
                ledger.held_slots.delete(idx);
            end
            addr = {$urandom, $urandom};
            if ($urandom_range(3) == 0)
                addr = {56'h0, 8'($urandom)};
            req.address = addr;
        end
        send_req(req, gap_pct);
    endtask

    initial
    begin
        int n_seg;
        ledger = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero record, match and clear, null free, edge slots, double free
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h0), 30);
        send_req(make_req(OP_GET,  8'd255, 1'b1, {64{1'b1}}), 30);
        send_req(make_req(OP_FREE, 8'd1,   1'b0, {64{1'b1}}), 30);
        send_req(make_req(OP_GET,  8'd0,   1'b0, {64{1'b1}}), 30);
        send_req(make_req(OP_FREE, 8'd255, 1'b1, 64'h123), 30);
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h124), 30);
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h0), 30);
        send_req(make_req(OP_FREE, 8'd255, 1'b0, 64'hA5A5_5A5A_0F0F_F0F0), 30);
        send_req(make_req(OP_FREE, 8'd0,   1'b0, 64'h5A5A_A5A5_F0F0_0F0F), 30);
        send_req(make_req(OP_FREE, 8'd0,   1'b0, 64'h5A5A_A5A5_F0F0_0F0F), 30);
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h5A5A_A5A5_F0F0_0F0F), 0);
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h5A5A_A5A5_F0F0_0F0F), 0);
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h0), 0);
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h8000_0000_0000_0001), 0);
        send_req(make_req(OP_FREE, 8'd7,   1'b0, 64'h8000_0000_0000_0000), 0);
        send_req(make_req(OP_FREE, 8'd0,   1'b1, 64'h1), 0);
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h1), 20);
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h7FFF_FFFF_FFFF_FFFF), 20);
        send_req(make_req(OP_FREE, 8'd128, 1'b0, 64'h0), 20);
        send_req(make_req(OP_GET,  8'd0,   1'b0, 64'h0), 20);

        // Drain the fresh slots with a get-heavy stretch
        repeat (320) send_random(92, 25);

        // Mixed segments with varying balance and idling
        n_seg = 0;
        while (ledger.n_requests < 1300)
        begin
            case ($urandom_range(4))
                0: repeat (60) send_random(20, 40);
                1: repeat (60) send_random(50, 0);
                2: repeat (60) send_random(75, 15);
                3: repeat (60) send_random(97, 40);
                default: repeat (60) send_random(50, 15);
            endcase
            n_seg++;
        end

        // Final stretch with no idling on either side
        quiet = 1'b1;
        repeat (150) send_random(60, 0);
        in_valid <= 1'b0;

        while (ledger.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d requests in %0d mixed segments: %0d frees, %0d grants",
                 ledger.n_requests, n_seg, ledger.n_frees, ledger.n_grants);
        $display("exhausted gets %0d, definalize hits %0d, long receiver hold-off %0b",
                 ledger.n_exhausted, ledger.n_definalize, held_off);
        if (ledger.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/lsa_pkg.sv
rtl/core/lsa_ctrl.sv
rtl/core/lsa_datapath.sv
rtl/core/location_slot_allocator.sv
dv/location_slot_allocator_tb.sv
